### hw/rtl/crrd_pkg.sv
// Package with the shared types and constants of the capacity round-robin dispatcher.
package crrd_pkg;

    // Command codes carried in a request.
    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_ASSIGN = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_CRASH  = 2'd3
    } cmd_t;

    // Status codes carried in a result.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERLOAD = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // Configuration register indexes.
    localparam int unsigned REG_THRESHOLD = 0;
    localparam int unsigned REG_LAPS      = 1;

    localparam logic [7:0] THRESHOLD_RESET = 8'd5;
    localparam logic [1:0] LAPS_RESET      = 2'd2;
    localparam logic [7:0] COUNT_MAX       = 8'd255;
    localparam logic [1:0] LAPS_MAX        = 2'd3;

    // One worker record.
    typedef struct packed {
        logic [7:0] id;
        logic [7:0] load;
        logic [7:0] capacity;
        logic       resting;
        logic [7:0] work_count;
        logic [1:0] rest_laps;
    } worker_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] worker_id;
        logic [7:0] worker_capacity;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] served_id;
        logic [7:0] unplaced_jobs;
    } rsp_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_ASSIGN,
        S_FIND,
        S_SPREAD,
        S_REMOVE,
        S_RESULT
    } state_t;

    // Per-cycle control from the sequencer to every cell.
    typedef struct packed {
        logic       shift_up;    // shift records toward higher slots
        logic       shift_down;  // shift records toward lower slots
        logic       tick;        // one rest lap on every live cell
        logic       load_new;    // write the new worker at the insert slot
        logic       bump;        // give one job at the selected slot
        logic       add_load;    // add take to the load at the selected slot
    } cell_ctl_t;

endpackage

### hw/rtl/capacity_round_robin_dispatcher_core.sv
// Top level of the capacity round-robin dispatcher: APB registers, sequencer and cell row.
//
// Requests arrive on req_valid/req_ready carrying cmd, worker_id and
// worker_capacity; each produces exactly one result on rsp_valid/rsp_ready
// with status, served_id and unplaced_jobs.
// The block handles one request at a time. A tick or a rejected request
// goes straight to its result; an add takes one insert step; an assign
// walks the ring from the current position until it finds a free worker or
// has visited every worker; a crash searches the ring for its worker, then
// spreads that worker's load over each other worker and removes it.
// After the result is taken the block returns to idle, and only then is ready.
// The sequencer visits one cell per cycle.
// The worker records sit in a row of cells that shift toward their
// neighbors on inserts and removals.
// The result is held until rsp_ready; no new request is taken meanwhile.
// Reset empties the ring, zeroes every record, loads rest_threshold 5 and rest_laps 2.
// The user must write registers through the APB port only while idle; not enforced.
module capacity_round_robin_dispatcher_core #(
    parameter int unsigned SLOTS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  crrd_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output crrd_pkg::rsp_t rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int unsigned IW = $clog2(SLOTS);
    localparam int unsigned CW = $clog2(SLOTS + 1);

    logic [7:0] threshold_reg;
    logic [1:0] laps_reg;
    crrd_pkg::cell_ctl_t ctl;
    logic [IW-1:0] sel_idx;
    logic [IW-1:0] edge_idx;
    logic [CW-1:0] count;
    logic [7:0]    take;
    crrd_pkg::worker_t recs [SLOTS];
    crrd_pkg::worker_t new_rec;
    crrd_pkg::req_t    req_hold_reg;
    logic          wr;

    // Configuration registers.
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= crrd_pkg::THRESHOLD_RESET;
            laps_reg      <= crrd_pkg::LAPS_RESET;
        end
        else if (wr)
        begin
            if (paddr[2] == 1'(crrd_pkg::REG_THRESHOLD))
            begin
                threshold_reg <= pwdata[7:0];
            end
            else
            begin
                laps_reg <= pwdata[1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == 1'(crrd_pkg::REG_LAPS))
        begin
            prdata = {30'd0, laps_reg};
        end
        else
        begin
            prdata = {24'd0, threshold_reg};
        end
    end

    // Copy of the accepted request, since the sender may move on after acceptance.
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_hold_reg <= req;
        end
    end

    // New worker record for an add.
    always_comb
    begin
        new_rec          = '0;
        new_rec.id       = req_hold_reg.worker_id;
        new_rec.capacity = req_hold_reg.worker_capacity;
    end

    crrd_seq #(.SLOTS(SLOTS)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cur_rec   (recs[sel_idx]),
        .ctl       (ctl),
        .sel_idx   (sel_idx),
        .edge_idx  (edge_idx),
        .count     (count),
        .take      (take)
    );

    // Row of cells; each takes its neighbors' records on shifts.
    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        localparam int unsigned BELOW = (g == 0) ? 0 : g - 1;
        localparam int unsigned ABOVE = (g == SLOTS - 1) ? g : g + 1;
        logic live;
        logic up_en;
        logic down_en;
        assign live    = CW'(g) < count;
        assign up_en   = (IW'(g) > edge_idx) && (CW'(g) <= count);
        assign down_en = (IW'(g) >= edge_idx) && (CW'(g + 1) < count);
        crrd_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .live       (live),
            .sel        (sel_idx == IW'(g)),
            .up_en      (up_en),
            .down_en    (down_en),
            .from_below (recs[BELOW]),
            .from_above (recs[ABOVE]),
            .new_rec    (new_rec),
            .take       (take),
            .threshold  (threshold_reg),
            .laps       (laps_reg),
            .rec        (recs[g])
        );
    end

endmodule

### hw/rtl/crrd_cell.sv
// One ring cell: holds a worker record and passes it to its neighbors on shifts.
module crrd_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  crrd_pkg::cell_ctl_t  ctl,
    input  logic                 live,
    input  logic                 sel,
    input  logic                 up_en,
    input  logic                 down_en,
    input  crrd_pkg::worker_t    from_below,
    input  crrd_pkg::worker_t    from_above,
    input  crrd_pkg::worker_t    new_rec,
    input  logic [7:0]           take,
    input  logic [7:0]           threshold,
    input  logic [1:0]           laps,
    output crrd_pkg::worker_t    rec
);

    crrd_pkg::worker_t rec_reg;
    crrd_pkg::worker_t rec_next;
    crrd_pkg::worker_t ticked;

    // Rest bookkeeping for a tick.
    always_comb
    begin
        ticked = rec_reg;
        if (rec_reg.work_count >= threshold)
        begin
            ticked.resting = 1'b1;
        end
        if (ticked.resting)
        begin
            if (rec_reg.rest_laps < crrd_pkg::LAPS_MAX)
            begin
                ticked.rest_laps = rec_reg.rest_laps + 2'd1;
            end
            if (ticked.rest_laps >= laps)
            begin
                ticked.resting    = 1'b0;
                ticked.work_count = '0;
                ticked.rest_laps  = '0;
            end
        end
    end

    // Next record selection.
    always_comb
    begin
        rec_next = rec_reg;
        priority if (ctl.load_new && sel)
        begin
            rec_next = new_rec;
        end
        else if (ctl.shift_up && up_en)
        begin
            rec_next = from_below;
        end
        else if (ctl.shift_down && down_en)
        begin
            rec_next = from_above;
        end
        else if (ctl.tick && live)
        begin
            rec_next = ticked;
        end
        else if (ctl.bump && sel)
        begin
            rec_next.load = rec_reg.load + 8'd1;
            if (rec_reg.work_count != crrd_pkg::COUNT_MAX)
            begin
                rec_next.work_count = rec_reg.work_count + 8'd1;
            end
        end
        else if (ctl.add_load && sel)
        begin
            rec_next.load = rec_reg.load + take;
        end
    end

    // Record register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec = rec_reg;

endmodule

### hw/rtl/crrd_seq.sv
// Sequencer that walks the ring one slot per cycle and drives the cell row.
module crrd_seq #(
    parameter int unsigned SLOTS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  crrd_pkg::req_t              req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output crrd_pkg::rsp_t              rsp,
    input  crrd_pkg::worker_t           cur_rec,
    output crrd_pkg::cell_ctl_t         ctl,
    output logic [$clog2(SLOTS)-1:0]    sel_idx,
    output logic [$clog2(SLOTS)-1:0]    edge_idx,
    output logic [$clog2(SLOTS+1)-1:0]  count,
    output logic [7:0]                  take
);

    localparam int unsigned IW = $clog2(SLOTS);
    localparam int unsigned CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] FULL = CW'(SLOTS);

    crrd_pkg::state_t state_reg, state_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [CW-1:0] steps_reg, steps_next;
    logic [IW-1:0] victim_reg, victim_next;
    logic [7:0]    left_reg, left_next;
    logic [7:0]    wid_reg;
    crrd_pkg::rsp_t rsp_reg, rsp_next;
    logic [IW-1:0] idx_inc;
    logic [7:0]    room;
    logic          free;
    logic          last;

    // Ring successor of the walk index.
    always_comb
    begin
        if ({1'b0, idx_reg} + 1'b1 >= {1'b0, cnt_reg})
        begin
            idx_inc = '0;
        end
        else
        begin
            idx_inc = idx_reg + 1'b1;
        end
    end

    assign room = (cur_rec.load >= cur_rec.capacity) ? 8'd0
                : cur_rec.capacity - cur_rec.load;
    assign free = !cur_rec.resting && (room != 8'd0);
    assign take = (room < left_reg) ? room : left_reg;
    assign last = (steps_reg + 1'b1 >= cnt_reg);

    // Next state and registers.
    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        steps_next  = steps_reg;
        victim_next = victim_reg;
        left_next   = left_reg;
        rsp_next    = rsp_reg;
        unique case (state_reg)
            crrd_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    rsp_next  = '0;
                    idx_next  = pos_reg;
                    steps_next = '0;
                    unique case (crrd_pkg::cmd_t'(req.cmd))
                        crrd_pkg::CMD_ADD:
                        begin
                            if (cnt_reg >= FULL)
                            begin
                                rsp_next.status = crrd_pkg::ST_FULL;
                                state_next = crrd_pkg::S_RESULT;
                            end
                            else
                            begin
                                state_next = crrd_pkg::S_ADD;
                            end
                        end
                        crrd_pkg::CMD_ASSIGN:
                        begin
                            if (cnt_reg == '0)
                            begin
                                rsp_next.status = crrd_pkg::ST_NOTFOUND;
                                state_next = crrd_pkg::S_RESULT;
                            end
                            else
                            begin
                                state_next = crrd_pkg::S_ASSIGN;
                            end
                        end
                        crrd_pkg::CMD_TICK:
                        begin
                            state_next = crrd_pkg::S_RESULT;
                        end
                        crrd_pkg::CMD_CRASH:
                        begin
                            if (cnt_reg == '0)
                            begin
                                rsp_next.status = crrd_pkg::ST_NOTFOUND;
                                state_next = crrd_pkg::S_RESULT;
                            end
                            else
                            begin
                                state_next = crrd_pkg::S_FIND;
                            end
                        end
                        default:
                        begin
                            state_next = crrd_pkg::S_RESULT;
                        end
                    endcase
                end
            end
            crrd_pkg::S_ADD:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '0)
                begin
                    pos_next = '0;
                end
                state_next = crrd_pkg::S_RESULT;
            end
            crrd_pkg::S_ASSIGN:
            begin
                if (free)
                begin
                    rsp_next.served_id = cur_rec.id;
                    pos_next   = idx_inc;
                    state_next = crrd_pkg::S_RESULT;
                end
                else if (last)
                begin
                    rsp_next.status = crrd_pkg::ST_OVERLOAD;
                    state_next = crrd_pkg::S_RESULT;
                end
                else
                begin
                    idx_next   = idx_inc;
                    steps_next = steps_reg + 1'b1;
                end
            end
            crrd_pkg::S_FIND:
            begin
                if (cur_rec.id == wid_reg)
                begin
                    victim_next = idx_reg;
                    left_next   = cur_rec.load;
                    idx_next    = idx_inc;
                    steps_next  = CW'(1);
                    state_next  = (cnt_reg == CW'(1)) ? crrd_pkg::S_REMOVE
                                                      : crrd_pkg::S_SPREAD;
                end
                else if (last)
                begin
                    rsp_next.status = crrd_pkg::ST_NOTFOUND;
                    state_next = crrd_pkg::S_RESULT;
                end
                else
                begin
                    idx_next   = idx_inc;
                    steps_next = steps_reg + 1'b1;
                end
            end
            crrd_pkg::S_SPREAD:
            begin
                left_next  = left_reg - take;
                idx_next   = idx_inc;
                steps_next = steps_reg + 1'b1;
                if (last)
                begin
                    state_next = crrd_pkg::S_REMOVE;
                end
            end
            crrd_pkg::S_REMOVE:
            begin
                rsp_next.unplaced_jobs = left_reg;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    pos_next = '0;
                end
                else if (pos_reg == victim_reg)
                begin
                    if ({1'b0, victim_reg} >= cnt_reg - 1'b1)
                    begin
                        pos_next = '0;
                    end
                end
                else if (pos_reg > victim_reg)
                begin
                    pos_next = pos_reg - 1'b1;
                end
                state_next = crrd_pkg::S_RESULT;
            end
            crrd_pkg::S_RESULT:
            begin
                if (rsp_ready)
                begin
                    state_next = crrd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = crrd_pkg::S_IDLE;
            end
        endcase
    end

    // Cell control outputs.
    always_comb
    begin
        ctl      = '0;
        sel_idx  = idx_reg;
        edge_idx = idx_reg;
        unique case (state_reg)
            crrd_pkg::S_IDLE:
            begin
                ctl.tick = req_valid && (crrd_pkg::cmd_t'(req.cmd) == crrd_pkg::CMD_TICK);
            end
            crrd_pkg::S_ADD:
            begin
                ctl.shift_up = (cnt_reg != '0);
                ctl.load_new = 1'b1;
                sel_idx  = (cnt_reg == '0) ? '0 : pos_reg + 1'b1;
                edge_idx = sel_idx;
            end
            crrd_pkg::S_ASSIGN:
            begin
                ctl.bump = free;
            end
            crrd_pkg::S_SPREAD:
            begin
                ctl.add_load = 1'b1;
            end
            crrd_pkg::S_REMOVE:
            begin
                ctl.shift_down = 1'b1;
                edge_idx = victim_reg;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= crrd_pkg::S_IDLE;
            pos_reg    <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Walk and payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        steps_reg  <= steps_next;
        victim_reg <= victim_next;
        left_reg   <= left_next;
        rsp_reg    <= rsp_next;
        if (state_reg == crrd_pkg::S_IDLE)
        begin
            wid_reg <= req.worker_id;
        end
    end

    assign req_ready = (state_reg == crrd_pkg::S_IDLE);
    assign rsp_valid = (state_reg == crrd_pkg::S_RESULT);
    assign rsp       = rsp_reg;
    assign count     = cnt_reg;

endmodule

### hw/rtl/crrd_checker.sv
// Port checker for the capacity round-robin dispatcher, bound to the top level.
module crrd_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input crrd_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input crrd_pkg::rsp_t rsp
);

    // A result stays offered until taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result dropped while stalled");

    // One request at a time: no new request while a result is pending.
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request taken while result pending");

    // A failed request reports no served id.
    a_served: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != crrd_pkg::ST_OK |-> rsp.served_id == 8'd0)
        else $error("served id on failed request");

    // A result that has been taken is not offered again.
    a_once: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready |=> !rsp_valid)
        else $error("result offered twice");

endmodule

bind capacity_round_robin_dispatcher_core crrd_checker u_crrd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
